// ===== hdl/velocity_verlet_triatomic_chain_macros.svh =====
// Assertion macros for the triatomic chain integrator.
// Both macros expect signals named clk and rst_n in the using scope.
`ifndef VELOCITY_VERLET_TRIATOMIC_CHAIN_MACROS_SVH
`define VELOCITY_VERLET_TRIATOMIC_CHAIN_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define VVTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vvtc: same-cycle check failed");
// next-cycle implication
`define VVTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vvtc: next-cycle check failed");
`else
`define VVTC_ASSERT_IMP(label, ante, cons)
`define VVTC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/vvtc_pkg.sv =====
// Shared types, constants, microprogram and saturation helpers for the
// triatomic chain integrator. No dependencies.
package vvtc_pkg;

    localparam int DW   = 48;            // data width
    localparam int FB   = 32;            // fraction bits
    localparam int PW   = 2 * DW;        // full product width
    localparam int HW   = DW / 2;        // partial product operand width
    localparam int CW   = DW - 1;        // register / energy width
    localparam int NW   = CW + FB;       // dividend width
    localparam int DCW  = $clog2(NW);    // divider counter width
    localparam int NP   = 3;             // particles
    localparam int PCW  = 5;             // microprogram counter width
    localparam int CIW  = 3;             // configuration index width
    localparam int IN_DW    = 2 * DW;
    localparam int IN_UW    = 3;
    localparam int OUT_BITS = 6 * DW + 2 * CW;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [PW:0]   WMAX = (PW+1)'(SMAX);
    localparam logic signed [PW:0]   WMIN = (PW+1)'(SMIN);

    // configuration register indexes
    localparam logic [CIW-1:0] REG_TIME_STEP       = 3'd0;
    localparam logic [CIW-1:0] REG_SPRING_CONSTANT = 3'd1;
    localparam logic [CIW-1:0] REG_MASS_FIRST      = 3'd2;
    localparam logic [CIW-1:0] REG_MASS_MIDDLE     = 3'd3;
    localparam logic [CIW-1:0] REG_MASS_LAST       = 3'd4;

    localparam logic [CW-1:0] RST_TIME_STEP       = CW'(64'd858993);
    localparam logic [CW-1:0] RST_SPRING_CONSTANT = CW'(64'd428745110323);
    localparam logic [CW-1:0] RST_MASS_OUTER      = CW'(64'd7121485);
    localparam logic [CW-1:0] RST_MASS_MIDDLE     = CW'(64'd5346376);

    // item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic [CW-1:0] time_step;
        logic [CW-1:0] spring_constant;
        logic [CW-1:0] mass_first;
        logic [CW-1:0] mass_middle;
        logic [CW-1:0] mass_last;
    } cfg_t;

    typedef struct packed {
        logic          start;
        logic          func;
        logic [1:0]    particle;
        logic [DW-1:0] pos;
        logic [DW-1:0] vel;
    } cmd_t;

    typedef struct packed {
        logic                   valid;
        logic [NP-1:0][DW-1:0]  pos;
        logic [NP-1:0][DW-1:0]  vel;
        logic [CW-1:0]          ekin;
        logic [CW-1:0]          epot;
    } res_t;

    typedef enum logic [1:0] {OP_DIFF, OP_MUL, OP_DIV, OP_END} op_t;

    typedef enum logic [4:0] {
        SRC_Q0, SRC_Q1, SRC_Q2, SRC_V0, SRC_V1, SRC_V2,
        SRC_A0, SRC_A1, SRC_A2, SRC_D0, SRC_D1, SRC_D2,
        SRC_R0, SRC_R1, SRC_R2, SRC_E1, SRC_S, SRC_DT,
        SRC_KAPPA, SRC_M0, SRC_M1, SRC_M2
    } src_t;

    typedef enum logic [3:0] {
        DST_Q0, DST_Q1, DST_Q2, DST_V0, DST_V1, DST_V2,
        DST_A0, DST_A1, DST_A2, DST_R0, DST_R1, DST_R2,
        DST_S, DST_EK, DST_EP
    } dst_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        logic half;   // shift by FB+1 instead of FB
        logic add;    // add the destination's old value
        dst_t dst;
    } uop_t;

    function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                                input logic half, input logic add, input dst_t dst);
        uop_t u;
        u.op = op; u.a = a; u.b = b; u.half = half; u.add = add; u.dst = dst;
        return u;
    endfunction

    // Step microprogram: ratios, accel, kick, drift, accel, kick, energies
    function automatic uop_t uop_at(input logic [PCW-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk(OP_DIV,  SRC_KAPPA, SRC_M0, 1'b0, 1'b0, DST_R0);
            5'd1:  u = mk(OP_DIV,  SRC_KAPPA, SRC_M1, 1'b0, 1'b0, DST_R1);
            5'd2:  u = mk(OP_DIV,  SRC_KAPPA, SRC_M2, 1'b0, 1'b0, DST_R2);
            5'd3:  u = mk(OP_DIFF, SRC_Q0, SRC_Q0, 1'b0, 1'b0, DST_S);
            5'd4:  u = mk(OP_MUL,  SRC_R0, SRC_D0, 1'b0, 1'b0, DST_A0);
            5'd5:  u = mk(OP_MUL,  SRC_R1, SRC_D1, 1'b0, 1'b0, DST_A1);
            5'd6:  u = mk(OP_MUL,  SRC_R2, SRC_D2, 1'b0, 1'b0, DST_A2);
            5'd7:  u = mk(OP_MUL,  SRC_DT, SRC_A0, 1'b1, 1'b1, DST_V0);
            5'd8:  u = mk(OP_MUL,  SRC_DT, SRC_A1, 1'b1, 1'b1, DST_V1);
            5'd9:  u = mk(OP_MUL,  SRC_DT, SRC_A2, 1'b1, 1'b1, DST_V2);
            5'd10: u = mk(OP_MUL,  SRC_DT, SRC_V0, 1'b0, 1'b1, DST_Q0);
            5'd11: u = mk(OP_MUL,  SRC_DT, SRC_V1, 1'b0, 1'b1, DST_Q1);
            5'd12: u = mk(OP_MUL,  SRC_DT, SRC_V2, 1'b0, 1'b1, DST_Q2);
            5'd13: u = mk(OP_DIFF, SRC_Q0, SRC_Q0, 1'b0, 1'b0, DST_S);
            5'd14: u = mk(OP_MUL,  SRC_R0, SRC_D0, 1'b0, 1'b0, DST_A0);
            5'd15: u = mk(OP_MUL,  SRC_R1, SRC_D1, 1'b0, 1'b0, DST_A1);
            5'd16: u = mk(OP_MUL,  SRC_R2, SRC_D2, 1'b0, 1'b0, DST_A2);
            5'd17: u = mk(OP_MUL,  SRC_DT, SRC_A0, 1'b1, 1'b1, DST_V0);
            5'd18: u = mk(OP_MUL,  SRC_DT, SRC_A1, 1'b1, 1'b1, DST_V1);
            5'd19: u = mk(OP_MUL,  SRC_DT, SRC_A2, 1'b1, 1'b1, DST_V2);
            5'd20: u = mk(OP_MUL,  SRC_V0, SRC_V0, 1'b0, 1'b0, DST_S);
            5'd21: u = mk(OP_MUL,  SRC_M0, SRC_S,  1'b1, 1'b0, DST_EK);
            5'd22: u = mk(OP_MUL,  SRC_V1, SRC_V1, 1'b0, 1'b0, DST_S);
            5'd23: u = mk(OP_MUL,  SRC_M1, SRC_S,  1'b1, 1'b0, DST_EK);
            5'd24: u = mk(OP_MUL,  SRC_V2, SRC_V2, 1'b0, 1'b0, DST_S);
            5'd25: u = mk(OP_MUL,  SRC_M2, SRC_S,  1'b1, 1'b0, DST_EK);
            5'd26: u = mk(OP_DIFF, SRC_Q0, SRC_Q0, 1'b0, 1'b0, DST_S);
            5'd27: u = mk(OP_MUL,  SRC_D0, SRC_D0, 1'b0, 1'b0, DST_S);
            5'd28: u = mk(OP_MUL,  SRC_KAPPA, SRC_S, 1'b1, 1'b0, DST_EP);
            5'd29: u = mk(OP_MUL,  SRC_E1, SRC_E1, 1'b0, 1'b0, DST_S);
            5'd30: u = mk(OP_MUL,  SRC_KAPPA, SRC_S, 1'b1, 1'b0, DST_EP);
            default: u = mk(OP_END, SRC_Q0, SRC_Q0, 1'b0, 1'b0, DST_S);
        endcase
        return u;
    endfunction

    // saturate a wide signed value to the data range
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [PW:0] x);
        logic signed [DW-1:0] r;
        if (x > WMAX)
            r = SMAX;
        else if (x < WMIN)
            r = SMIN;
        else
            r = x[DW-1:0];
        return r;
    endfunction

    // clamp an energy sum to [0, SMAX]
    function automatic logic [CW-1:0] clamp_cw(input logic signed [PW-1:0] x);
        logic [CW-1:0] r;
        if (x < 0)
            r = '0;
        else if (x > PW'(SMAX))
            r = SMAX[CW-1:0];
        else
            r = x[CW-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/velocity_verlet_triatomic_chain.sv =====
// Top level of the triatomic spring chain integrator: stream ports,
// configuration registers and output register. Depends on vvtc_pkg, vvtc_core.
//
// Three masses joined by two springs, advanced by velocity Verlet in signed
// Q16.32. A load transfer (tuser func = 0) sets one particle's position and
// velocity and yields no result. A step transfer (func = 1) runs a microprogram
// on one shared multi-cycle multiplier (four 24x24 partial products each) and
// one bit-serial divider (one kappa/m ratio per division, three per step); a
// step is made of those three divisions and 25 products. s_axis_tready is low
// while a step is in progress. A finished result sits in the output register,
// so the next item is taken while it waits; a step holds at its end only if
// the previous result has not yet been taken. The user must write the
// configuration only while idle; the block itself does not enforce it.
module velocity_verlet_triatomic_chain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // load_position, load_velocity
    input  logic [vvtc_pkg::IN_DW-1:0]     s_axis_tdata,
    // func, particle
    input  logic [vvtc_pkg::IN_UW-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // position_first/middle/last, velocity_first/middle/last,
    // kinetic_energy, potential_energy, zero pad
    output logic [vvtc_pkg::OUT_DW-1:0]    m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [vvtc_pkg::CIW-1:0]       cfg_index,
    input  logic [vvtc_pkg::CW-1:0]        cfg_data
);
    import vvtc_pkg::*;

    cfg_t              cfg_reg;
    cmd_t              cmd;
    res_t              res;
    logic              core_idle;
    logic              out_free;
    logic              m_valid_reg;
    logic [OUT_DW-1:0] m_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step       <= RST_TIME_STEP;
            cfg_reg.spring_constant <= RST_SPRING_CONSTANT;
            cfg_reg.mass_first      <= RST_MASS_OUTER;
            cfg_reg.mass_middle     <= RST_MASS_MIDDLE;
            cfg_reg.mass_last       <= RST_MASS_OUTER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIME_STEP:       cfg_reg.time_step       <= cfg_data;
                REG_SPRING_CONSTANT: cfg_reg.spring_constant <= cfg_data;
                REG_MASS_FIRST:      cfg_reg.mass_first      <= cfg_data;
                REG_MASS_MIDDLE:     cfg_reg.mass_middle     <= cfg_data;
                REG_MASS_LAST:       cfg_reg.mass_last       <= cfg_data;
                default: ;
            endcase
        end
    end

    // input transfer
    assign s_axis_tready = core_idle;
    assign cmd.start     = s_axis_tvalid && core_idle;
    assign cmd.func      = s_axis_tuser[0];
    assign cmd.particle  = s_axis_tuser[2:1];
    assign cmd.pos       = s_axis_tdata[DW-1:0];
    assign cmd.vel       = s_axis_tdata[2*DW-1:DW];

    vvtc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .out_free (out_free),
        .res      (res),
        .idle     (core_idle)
    );

    // output register
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (res.valid && out_free)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
            m_data_reg <= {{(OUT_DW-OUT_BITS){1'b0}}, res.epot, res.ekin, res.vel, res.pos};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== hdl/vvtc_mul.sv =====
// Multi-cycle signed DW x DW multiplier built from four HW x HW partial products.
// Depends on vvtc_pkg.
module vvtc_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [vvtc_pkg::DW-1:0] a,
    input  logic signed [vvtc_pkg::DW-1:0] b,
    output logic                          done,
    output logic signed [vvtc_pkg::PW-1:0] p
);
    import vvtc_pkg::*;

    logic          run_reg;
    logic [2:0]    cnt_reg;
    logic [DW-1:0] ma_reg, mb_reg;
    logic          neg_reg;
    logic [DW-1:0] prod_reg;
    logic [1:0]    psh_reg;
    logic          pv_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] p_reg;
    logic          done_reg;

    logic          pi, pj;
    logic [HW-1:0] ha, hb;
    logic [DW-1:0] pprod;
    logic [PW-1:0] pshift;
    logic [DW-1:0] abs_a, abs_b;

    // operand magnitudes
    assign abs_a = a[DW-1] ? (~a + 1'b1) : a;
    assign abs_b = b[DW-1] ? (~b + 1'b1) : b;

    // partial product select
    assign pi     = cnt_reg[1];
    assign pj     = cnt_reg[0];
    assign ha     = pi ? ma_reg[DW-1:HW] : ma_reg[HW-1:0];
    assign hb     = pj ? mb_reg[DW-1:HW] : mb_reg[HW-1:0];
    assign pprod  = ha * hb;
    assign pshift = PW'(prod_reg) << (psh_reg * HW);

    // sequence: four products, accumulate one behind, then sign fix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                pv_reg  <= 1'b0;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                pv_reg  <= ~cnt_reg[2];
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= abs_a;
            mb_reg  <= abs_b;
            neg_reg <= a[DW-1] ^ b[DW-1];
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!cnt_reg[2])
            begin
                prod_reg <= pprod;
                psh_reg  <= {1'b0, pi} + {1'b0, pj};
            end
            if (pv_reg)
                acc_reg <= acc_reg + pshift;
            if (cnt_reg == 3'd5)
                p_reg <= neg_reg ? (~acc_reg + 1'b1) : acc_reg;
        end
    end

    assign done = done_reg;
    assign p    = $signed(p_reg);

endmodule

// ===== hdl/vvtc_div.sv =====
// Restoring divider, one quotient bit per cycle, for (kappa << FB) / mass.
// Saturates the quotient to the positive data range. Depends on vvtc_pkg.
module vvtc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vvtc_pkg::CW-1:0]       num,
    input  logic [vvtc_pkg::CW-1:0]       den,
    output logic                          done,
    output logic signed [vvtc_pkg::DW-1:0] quot
);
    import vvtc_pkg::*;

    localparam logic [NW-1:0] QMAX = {{(NW-CW){1'b0}}, {CW{1'b1}}};

    logic           busy_reg;
    logic [DCW-1:0] cnt_reg;
    logic [NW-1:0]  num_reg;
    logic [CW-1:0]  den_reg;
    logic [CW-1:0]  rem_reg;
    logic [NW-1:0]  q_reg;
    logic           done_reg;
    logic [DW-1:0]  quot_reg;

    logic [DW-1:0]  rem_sh, rem_sub;
    logic           ge;
    logic [NW-1:0]  q_new;

    // one restoring step (zero divisor yields all ones, then saturates)
    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign q_new   = {q_reg[NW-2:0], ge};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCW'(NW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {num, {FB{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= rem_sub[CW-1:0];
            q_reg   <= q_new;
            if (cnt_reg == '0)
                quot_reg <= (q_new > QMAX) ? SMAX : q_new[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = $signed(quot_reg);

endmodule

// ===== hdl/vvtc_core.sv =====
// Microcoded sequencer and state registers of the integrator; drives the
// shared multiplier and divider. Depends on vvtc_pkg, vvtc_mul, vvtc_div and the macros header.
`include "velocity_verlet_triatomic_chain_macros.svh"
module vvtc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  vvtc_pkg::cfg_t   cfg,
    input  vvtc_pkg::cmd_t   cmd,
    input  logic             out_free,
    output vvtc_pkg::res_t   res,
    output logic             idle
);
    import vvtc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_MWAIT = 5'b00100,
        S_DWAIT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [PCW-1:0]       pc_reg, pc_next;
    logic signed [DW-1:0] q_reg [NP];
    logic signed [DW-1:0] v_reg [NP];
    logic signed [DW-1:0] a_reg [NP];
    logic signed [DW-1:0] r_reg [NP];
    logic signed [DW-1:0] d_reg [NP];
    logic signed [DW-1:0] e1_reg;
    logic signed [DW-1:0] s_reg;
    logic signed [PW-1:0] ek_reg, ep_reg;

    uop_t                 uop;
    logic signed [DW-1:0] opa, opb, cur_dst, addend, wb_val;
    logic signed [PW-1:0] shifted;
    logic signed [PW:0]   wsum;
    logic signed [DW+1:0] dq0, dq1, dq2, de1;
    logic                 mul_start, mul_done, div_start, div_done;
    logic signed [PW-1:0] mul_p;
    logic signed [DW-1:0] div_q;

    function automatic logic signed [DW-1:0] cfg_val(input logic [CW-1:0] x);
        return $signed({1'b0, x});
    endfunction

    function automatic logic signed [DW-1:0] src_val(input src_t s);
        logic signed [DW-1:0] r;
        case (s)
            SRC_Q0:    r = q_reg[0];
            SRC_Q1:    r = q_reg[1];
            SRC_Q2:    r = q_reg[2];
            SRC_V0:    r = v_reg[0];
            SRC_V1:    r = v_reg[1];
            SRC_V2:    r = v_reg[2];
            SRC_A0:    r = a_reg[0];
            SRC_A1:    r = a_reg[1];
            SRC_A2:    r = a_reg[2];
            SRC_D0:    r = d_reg[0];
            SRC_D1:    r = d_reg[1];
            SRC_D2:    r = d_reg[2];
            SRC_R0:    r = r_reg[0];
            SRC_R1:    r = r_reg[1];
            SRC_R2:    r = r_reg[2];
            SRC_E1:    r = e1_reg;
            SRC_S:     r = s_reg;
            SRC_DT:    r = cfg_val(cfg.time_step);
            SRC_KAPPA: r = cfg_val(cfg.spring_constant);
            SRC_M0:    r = cfg_val(cfg.mass_first);
            SRC_M1:    r = cfg_val(cfg.mass_middle);
            SRC_M2:    r = cfg_val(cfg.mass_last);
            default:   r = '0;
        endcase
        return r;
    endfunction

    // operand fetch
    assign uop = uop_at(pc_reg);
    always_comb
    begin
        opa = src_val(uop.a);
        opb = src_val(uop.b);
    end

    // old value of an accumulating destination
    always_comb
    begin
        case (uop.dst)
            DST_Q0:  cur_dst = q_reg[0];
            DST_Q1:  cur_dst = q_reg[1];
            DST_Q2:  cur_dst = q_reg[2];
            DST_V0:  cur_dst = v_reg[0];
            DST_V1:  cur_dst = v_reg[1];
            DST_V2:  cur_dst = v_reg[2];
            default: cur_dst = '0;
        endcase
        addend = uop.add ? cur_dst : SMAX ^ SMAX;
    end

    // writeback: floor shift, optional add, saturate
    assign shifted = uop.half ? (mul_p >>> (FB + 1)) : (mul_p >>> FB);
    assign wsum    = (PW+1)'(shifted) + (PW+1)'(addend);
    assign wb_val  = sat_dw(wsum);

    // neighbour differences, exact then saturated
    assign dq0 = (DW+2)'(q_reg[1]) - (DW+2)'(q_reg[0]);
    assign dq1 = (DW+2)'(q_reg[0]) + (DW+2)'(q_reg[2]) - ((DW+2)'(q_reg[1]) <<< 1);
    assign dq2 = (DW+2)'(q_reg[1]) - (DW+2)'(q_reg[2]);
    assign de1 = (DW+2)'(q_reg[2]) - (DW+2)'(q_reg[1]);

    assign mul_start = (state_reg == S_ISSUE) && (uop.op == OP_MUL);
    assign div_start = (state_reg == S_ISSUE) && (uop.op == OP_DIV);

    vvtc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .p     (mul_p)
    );

    vvtc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (cfg.spring_constant),
        .den   (opb[CW-1:0]),
        .done  (div_done),
        .quot  (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start && (cmd.func == FUNC_STEP))
                begin
                    state_next = S_ISSUE;
                    pc_next    = '0;
                end
            end
            S_ISSUE:
            begin
                case (uop.op)
                    OP_DIFF: pc_next    = pc_reg + 1'b1;
                    OP_MUL:  state_next = S_MWAIT;
                    OP_DIV:  state_next = S_DWAIT;
                    default: state_next = S_DONE;
                endcase
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_ISSUE;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_ISSUE;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // particle state: loads and writeback
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                q_reg[i] <= '0;
                v_reg[i] <= '0;
            end
        end
        else if ((state_reg == S_IDLE) && cmd.start && (cmd.func == FUNC_LOAD))
        begin
            case (cmd.particle)
                2'd0:
                begin
                    q_reg[0] <= $signed(cmd.pos);
                    v_reg[0] <= $signed(cmd.vel);
                end
                2'd1:
                begin
                    q_reg[1] <= $signed(cmd.pos);
                    v_reg[1] <= $signed(cmd.vel);
                end
                2'd2:
                begin
                    q_reg[2] <= $signed(cmd.pos);
                    v_reg[2] <= $signed(cmd.vel);
                end
                default: ;  // index three is ignored
            endcase
        end
        else if ((state_reg == S_MWAIT) && mul_done)
        begin
            case (uop.dst)
                DST_Q0:  q_reg[0] <= wb_val;
                DST_Q1:  q_reg[1] <= wb_val;
                DST_Q2:  q_reg[2] <= wb_val;
                DST_V0:  v_reg[0] <= wb_val;
                DST_V1:  v_reg[1] <= wb_val;
                DST_V2:  v_reg[2] <= wb_val;
                default: ;
            endcase
        end
    end

    // scratch registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && cmd.start)
        begin
            ek_reg <= '0;
            ep_reg <= '0;
        end
        else if ((state_reg == S_ISSUE) && (uop.op == OP_DIFF))
        begin
            d_reg[0] <= sat_dw((PW+1)'(dq0));
            d_reg[1] <= sat_dw((PW+1)'(dq1));
            d_reg[2] <= sat_dw((PW+1)'(dq2));
            e1_reg   <= sat_dw((PW+1)'(de1));
        end
        else if ((state_reg == S_MWAIT) && mul_done)
        begin
            case (uop.dst)
                DST_A0:  a_reg[0] <= wb_val;
                DST_A1:  a_reg[1] <= wb_val;
                DST_A2:  a_reg[2] <= wb_val;
                DST_S:   s_reg    <= wb_val;
                DST_EK:  ek_reg   <= ek_reg + shifted;
                DST_EP:  ep_reg   <= ep_reg + shifted;
                default: ;
            endcase
        end
        else if ((state_reg == S_DWAIT) && div_done)
        begin
            case (uop.dst)
                DST_R0:  r_reg[0] <= div_q;
                DST_R1:  r_reg[1] <= div_q;
                DST_R2:  r_reg[2] <= div_q;
                default: ;
            endcase
        end
    end

    // result
    always_comb
    begin
        res.valid = (state_reg == S_DONE);
        for (int i = 0; i < NP; i++)
        begin
            res.pos[i] = q_reg[i];
            res.vel[i] = v_reg[i];
        end
        res.ekin = clamp_cw(ek_reg);
        res.epot = clamp_cw(ep_reg);
    end

    assign idle = (state_reg == S_IDLE);

    `VVTC_ASSERT_IMP(a_mul_done_in_wait, mul_done, state_reg == S_MWAIT)
    `VVTC_ASSERT_IMP(a_div_done_in_wait, div_done, state_reg == S_DWAIT)
    `VVTC_ASSERT_IMP(a_start_when_idle, cmd.start, state_reg == S_IDLE)
    `VVTC_ASSERT_NEXT(a_done_releases, (state_reg == S_DONE) && out_free, state_reg == S_IDLE)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the triatomic spring chain integrator.
// It predicts every step result and compares it field by field. Depends on vvtc_pkg and the top level.
`timescale 1ns / 1ps

module testbench;

    import vvtc_pkg::*;

    typedef logic signed [DW-1:0]  word_t;
    typedef logic signed [127:0]   wide_t;

    typedef struct {
        logic        func;
        logic [1:0]  particle;
        word_t       pos;
        word_t       vel;
    } chain_item_t;

    typedef struct {
        word_t         pos [NP];
        word_t         vel [NP];
        logic [CW-1:0] ekin;
        logic [CW-1:0] epot;
    } chain_state_t;

    localparam wide_t W_HI = 128'sd140737488355327;
    localparam wide_t W_LO = -128'sd140737488355328;
    localparam int    SETTLE_CYCLES = 600;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DW-1:0]     s_axis_tdata;
    logic [IN_UW-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_DW-1:0]    m_axis_tdata;
    logic                 cfg_we;
    logic [CIW-1:0]       cfg_index;
    logic [CW-1:0]        cfg_data;

    chain_item_t   pending_items [$];
    chain_state_t  expected_states [$];
    logic [CW-1:0] cfg_shadow [5];
    word_t         pos_state [NP];
    word_t         vel_state [NP];
    int            errors;
    int            send_gap;
    int            recv_gap;
    logic          in_fire;
    logic          quiet;

    velocity_verlet_triatomic_chain u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- arithmetic of the predictor ----------------

    function automatic wide_t widen(input word_t x);
        return $signed({{(128-DW){x[DW-1]}}, x});
    endfunction

    function automatic wide_t widen_reg(input logic [CW-1:0] x);
        return $signed({{(128-CW){1'b0}}, x});
    endfunction

    // saturate to the signed data range
    function automatic word_t clip(input wide_t x);
        word_t r;
        if (x > W_HI)
            r = W_HI[DW-1:0];
        else if (x < W_LO)
            r = W_LO[DW-1:0];
        else
            r = x[DW-1:0];
        return r;
    endfunction

    // kappa << F over m, truncated; zero mass or overflow gives the maximum
    function automatic word_t spring_ratio(input logic [CW-1:0] kappa, input logic [CW-1:0] m);
        logic [127:0] q;
        word_t        r;
        if (m == '0)
            r = W_HI[DW-1:0];
        else
        begin
            q = ({81'd0, kappa} << FB) / {81'd0, m};
            r = (q > 128'(W_HI)) ? W_HI[DW-1:0] : q[DW-1:0];
        end
        return r;
    endfunction

    function automatic void chain_forces(output word_t acc [NP]);
        word_t d [NP];
        word_t r [NP];
        d[0] = clip(widen(pos_state[1]) - widen(pos_state[0]));
        d[1] = clip(widen(pos_state[0]) + widen(pos_state[2]) - 2 * widen(pos_state[1]));
        d[2] = clip(widen(pos_state[1]) - widen(pos_state[2]));
        for (int i = 0; i < NP; i++)
        begin
            r[i]   = spring_ratio(cfg_shadow[REG_SPRING_CONSTANT], cfg_shadow[REG_MASS_FIRST + i]);
            acc[i] = clip((widen(r[i]) * widen(d[i])) >>> FB);
        end
    endfunction

    function automatic void half_kick(input word_t acc [NP]);
        for (int i = 0; i < NP; i++)
            vel_state[i] = clip(widen(vel_state[i])
                + ((widen_reg(cfg_shadow[REG_TIME_STEP]) * widen(acc[i])) >>> (FB + 1)));
    endfunction

    function automatic wide_t energy_share(input wide_t c, input word_t x);
        word_t s;
        s = clip((widen(x) * widen(x)) >>> FB);
        return (c * widen(s)) >>> (FB + 1);
    endfunction

    function automatic logic [CW-1:0] energy_clamp(input wide_t sum);
        word_t e;
        e = clip(sum);
        return e[DW-1] ? '0 : e[CW-1:0];
    endfunction

    // apply one item to the chain; returns 1 with the new state for a step
    function automatic bit chain_advance(input chain_item_t it, output chain_state_t res);
        word_t acc [NP];
        wide_t sum;
        if (it.func == FUNC_LOAD)
        begin
            if (it.particle < 2'd3)
            begin
                pos_state[it.particle] = it.pos;
                vel_state[it.particle] = it.vel;
            end
            return 1'b0;
        end
        chain_forces(acc);
        half_kick(acc);
        for (int i = 0; i < NP; i++)
            pos_state[i] = clip(widen(pos_state[i])
                + ((widen_reg(cfg_shadow[REG_TIME_STEP]) * widen(vel_state[i])) >>> FB));
        chain_forces(acc);
        half_kick(acc);
        sum = 0;
        for (int i = 0; i < NP; i++)
            sum += energy_share(widen_reg(cfg_shadow[REG_MASS_FIRST + i]), vel_state[i]);
        res.ekin = energy_clamp(sum);
        sum = energy_share(widen_reg(cfg_shadow[REG_SPRING_CONSTANT]),
                           clip(widen(pos_state[1]) - widen(pos_state[0])))
            + energy_share(widen_reg(cfg_shadow[REG_SPRING_CONSTANT]),
                           clip(widen(pos_state[2]) - widen(pos_state[1])));
        res.epot = energy_clamp(sum);
        res.pos  = pos_state;
        res.vel  = vel_state;
        return 1'b1;
    endfunction

    // ---------------- driver and receiver ----------------

    always @(negedge clk)
    begin
        chain_item_t it;
        if (rst_n)
        begin
            // source side: next transfer once the current one has gone
            if (!s_axis_tvalid || in_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it            = pending_items.pop_front();
                    s_axis_tdata  <= {it.vel, it.pos};
                    s_axis_tuser  <= {it.particle, it.func};
                    s_axis_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 3);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // sink side: stall in short bursts
            if (recv_gap > 0)
            begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 3);
            end
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge clk)
    begin
        chain_item_t  it;
        chain_state_t res;
        chain_state_t want;
        word_t        got;
        logic [CW-1:0] got_e;
        if (rst_n)
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.pos      = s_axis_tdata[0 +: DW];
                it.vel      = s_axis_tdata[DW +: DW];
                it.func     = s_axis_tuser[0];
                it.particle = s_axis_tuser[2:1];
                if (chain_advance(it, res))
                    expected_states.push_back(res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_states.size() == 0)
                begin
                    $display("%0t: unexpected result transfer %h", $realtime, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    for (int i = 0; i < NP; i++)
                    begin
                        got = m_axis_tdata[DW*i +: DW];
                        if (got !== want.pos[i])
                        begin
                            $display("%0t: position %0d expected %h actual %h",
                                     $realtime, i, want.pos[i], got);
                            errors++;
                        end
                        got = m_axis_tdata[DW*(NP+i) +: DW];
                        if (got !== want.vel[i])
                        begin
                            $display("%0t: velocity %0d expected %h actual %h",
                                     $realtime, i, want.vel[i], got);
                            errors++;
                        end
                    end
                    got_e = m_axis_tdata[6*DW +: CW];
                    if (got_e !== want.ekin)
                    begin
                        $display("%0t: kinetic energy expected %h actual %h",
                                 $realtime, want.ekin, got_e);
                        errors++;
                    end
                    got_e = m_axis_tdata[6*DW+CW +: CW];
                    if (got_e !== want.epot)
                    begin
                        $display("%0t: potential energy expected %h actual %h",
                                 $realtime, want.epot, got_e);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // signed value of at most 2^(bits-1) in magnitude; 48 or more gives full range
    function automatic word_t rand_span(input int bits);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if (bits >= DW)
            return raw[DW-1:0];
        return $signed(raw[DW-1:0]) >>> (DW - bits);
    endfunction

    task automatic queue_load(input logic [1:0] p, input word_t q, input word_t v);
        chain_item_t it;
        it.func = FUNC_LOAD;
        it.particle = p;
        it.pos = q;
        it.vel = v;
        pending_items.push_back(it);
    endtask

    task automatic queue_step();
        chain_item_t it;
        it.func = FUNC_STEP;
        it.particle = 2'($urandom_range(0, 3));
        it.pos = rand_span(DW);
        it.vel = rand_span(DW);
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= REG_MASS_LAST)
            cfg_shadow[idx] = val;
    endtask

    task automatic write_all(input logic [CW-1:0] dt, input logic [CW-1:0] kappa,
                             input logic [CW-1:0] m0, input logic [CW-1:0] m1,
                             input logic [CW-1:0] m2);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_SPRING_CONSTANT, kappa);
        write_reg(REG_MASS_FIRST, m0);
        write_reg(REG_MASS_MIDDLE, m1);
        write_reg(REG_MASS_LAST, m2);
        // an index past the last register is dropped
        write_reg(CIW'(5 + $urandom_range(0, 2)), CW'({$urandom, $urandom}));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_states.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // at least n items: mostly load-all-then-steps runs, the rest loose noise
    task automatic queue_random(input int n, input int bits);
        int count;
        int k;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                for (int p = 0; p < NP; p++)
                    queue_load(2'(p), rand_span(bits), rand_span(bits));
                k = $urandom_range(1, 6);
                repeat (k) queue_step();
                count += NP + k;
            end
            else
            begin
                k = $urandom_range(0, 2);
                if (k == 0)
                    queue_step();
                else
                    queue_load(2'($urandom_range(0, 3)), rand_span(DW), rand_span(DW));
                count++;
            end
        end
    endtask

    function automatic logic [CW-1:0] rand_reg(input int lo, input int hi);
        return CW'({$urandom, $urandom} >> (64 - $urandom_range(lo, hi))) | CW'(1);
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        errors        = 0;
        send_gap      = 0;
        recv_gap      = 0;
        in_fire       = 1'b0;
        quiet         = 1'b0;
        cfg_shadow[REG_TIME_STEP]       = RST_TIME_STEP;
        cfg_shadow[REG_SPRING_CONSTANT] = RST_SPRING_CONSTANT;
        cfg_shadow[REG_MASS_FIRST]      = RST_MASS_OUTER;
        cfg_shadow[REG_MASS_MIDDLE]     = RST_MASS_MIDDLE;
        cfg_shadow[REG_MASS_LAST]       = RST_MASS_OUTER;
        for (int i = 0; i < NP; i++)
        begin
            pos_state[i] = '0;
            vel_state[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, the ignored fourth particle, a step from rest
        queue_step();
        queue_load(2'd0, W_HI[DW-1:0], W_LO[DW-1:0]);
        queue_load(2'd1, W_LO[DW-1:0], W_HI[DW-1:0]);
        queue_load(2'd2, W_HI[DW-1:0], W_HI[DW-1:0]);
        queue_step();
        queue_step();
        queue_load(2'd0, '0, '0);
        queue_load(2'd1, -48'sd1, -48'sd1);
        queue_load(2'd2, 48'sd1, 48'sd1);
        queue_step();
        queue_load(2'd0, 48'sd4294967296, '0);
        queue_load(2'd1, '0, 48'sd4294967296);
        queue_load(2'd2, -48'sd4294967296, '0);
        queue_step();
        queue_load(2'd3, W_HI[DW-1:0], W_LO[DW-1:0]);
        queue_step();
        queue_load(2'd3, '0, '0);
        queue_step();
        queue_step();
        queue_load(2'd1, W_LO[DW-1:0], W_LO[DW-1:0]);
        queue_step();
        wait_drained();

        // defaults, physical sizes
        queue_random(450, 34);
        wait_drained();

        // extremes: largest dt and kappa with unit masses
        write_all(W_HI[CW-1:0], W_HI[CW-1:0], CW'(1), CW'(1), CW'(1));
        queue_random(180, 40);
        wait_drained();

        // zero masses, zero spring, smallest dt
        write_all(CW'(1), '0, '0, '0, '0);
        queue_random(150, DW);
        wait_drained();

        // everything random over the whole range
        write_all(rand_reg(1, 47), rand_reg(1, 47), rand_reg(1, 47), rand_reg(1, 47),
                  rand_reg(1, 47));
        queue_random(250, DW);
        wait_drained();

        // realistic settings again, no idling from here on
        write_all(rand_reg(16, 24), rand_reg(30, 42), rand_reg(20, 30), rand_reg(20, 30),
                  rand_reg(20, 30));
        quiet = 1'b1;
        queue_random(700, 34);
        wait_drained();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
